// ===== sv/insulation_monitor_pwm_decoder_top_defines.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef INSULATION_MONITOR_PWM_DECODER_TOP_DEFINES_SVH
`define INSULATION_MONITOR_PWM_DECODER_TOP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication check.
`define IMPWM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");
// Next-cycle implication check.
`define IMPWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define IMPWM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define IMPWM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/impwm_pkg.sv =====
package impwm_pkg;

  // Default capture counter width.
  localparam int COUNTER_BITS_DEF = 32;

  // Reset value of the ticks-per-millisecond register.
  localparam logic [19:0] TPM_RESET = 20'd1000;

  // Scale factors of the rounded quotients.
  localparam int FREQ_SCALE = 2000;
  localparam int DUTY_SCALE = 51200;
  localparam int FREQ_SAT   = 255;
  localparam int PER_SAT    = 255;
  localparam int DUTY_SAT   = 25600;

  // Resistance formula coefficients.
  localparam int RES_SCALE = 1200;
  localparam int PCT       = 100;
  localparam int K_PER     = 95;
  localparam int K_DEN     = 5;

  // Duty windows in percent.
  localparam int WIN_START_LO = 15;
  localparam int WIN_START_HI = 85;
  localparam int WIN_FAULT_LO = 45;
  localparam int WIN_FAULT_HI = 55;

  // Status codes reported with every result.
  typedef enum logic [2:0] {
    ST_SHORT   = 3'd0,
    ST_NORMAL  = 3'd1,
    ST_UNDERV  = 3'd2,
    ST_START   = 3'd3,
    ST_DEVERR  = 3'd4,
    ST_EARTH   = 3'd5,
    ST_UNKNOWN = 3'd6
  } status_t;

  // Divider status toward the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Map a rounded frequency to its status code.
  function automatic status_t status_of(input logic [7:0] f);
    status_t s;
    unique case (f)
      8'd0:    s = ST_SHORT;
      8'd10:   s = ST_NORMAL;
      8'd20:   s = ST_UNDERV;
      8'd30:   s = ST_START;
      8'd40:   s = ST_DEVERR;
      8'd50:   s = ST_EARTH;
      default: s = ST_UNKNOWN;
    endcase
    return s;
  endfunction

endpackage

// ===== sv/impwm_div.sv =====
module impwm_div #(
  parameter int NW = 49,
  parameter int DW = 39
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [NW-1:0]         num,
  input  logic [DW-1:0]         den,
  output logic [NW-1:0]         quo,
  output impwm_pkg::div_stat_t  stat
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // One restoring step: bring down the next numerator bit and try to subtract.
  assign trial = {rem_r, quo_r[NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_nxt = {quo_r[NW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== sv/insulation_monitor_pwm_decoder_top.sv =====
// Sequence: each accepted beat runs the frequency, period and duty divisions (the first and
// last are skipped with no known period) and, for a resistance, one more division; each of
// up to four quotients runs in turn through the shared restoring divider.
// Throughput: one item at a time; in_tready rises together with the result beat, so a new
// item is taken only once the result is issued, and a stalled result holds the final step.
// Reset: synchronous, active low; clears timing state and sets ticks_per_ms to 1000.
`include "insulation_monitor_pwm_decoder_top_defines.svh"

module insulation_monitor_pwm_decoder_top #(
  parameter int COUNTER_BITS = impwm_pkg::COUNTER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // capture_time[31:0], pin_level[32], zero fill
  input  logic [0:0]  in_tuser,   // kind[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // detail_value[31:0], frequency_hz[39:32],
                                  // period_ms[47:40], duty_percent_q8[62:48], zero fill
  output logic [2:0]  out_tuser,  // status_code[2:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [19:0] cfg_data
);

  localparam int CB = COUNTER_BITS;
  localparam int NW = CB + 17;
  localparam int DW = CB + 7;
  localparam int HW = CB + 7;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_FREQ   = 10'b0000000010,
    S_PER    = 10'b0000000100,
    S_DUTY   = 10'b0000001000,
    S_DET    = 10'b0000010000,
    S_RESA   = 10'b0000100000,
    S_RESB   = 10'b0001000000,
    S_RESDIV = 10'b0010000000,
    S_WIN    = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t           state_r, state_nxt;
  logic             launched_r, launched_nxt;
  logic [19:0]      tpm_r, tpm_nxt;
  logic [CB-1:0]    last_rise_r, last_rise_nxt;
  logic [CB-1:0]    period_r, period_nxt;
  logic [CB-1:0]    high_r, high_nxt;
  logic             pin_r, pin_nxt;
  logic [7:0]       freq_r, freq_nxt;
  logic [7:0]       per_r, per_nxt;
  logic [14:0]      duty_r, duty_nxt;
  logic [31:0]      det_r, det_nxt;
  logic [HW-1:0]    h100_r, h100_nxt;
  logic             diff_neg_r, diff_neg_nxt;
  logic             den_neg_r, den_neg_nxt;
  logic [HW-1:0]    diff_mag_r, diff_mag_nxt;
  logic [HW-1:0]    den_mag_r, den_mag_nxt;
  logic [NW-1:0]    num_mag_r, num_mag_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic [2:0]       out_status_r, out_status_nxt;
  logic [31:0]      out_det_r, out_det_nxt;
  logic [7:0]       out_freq_r, out_freq_nxt;
  logic [7:0]       out_per_r, out_per_nxt;
  logic [14:0]      out_duty_r, out_duty_nxt;

  logic [19:0]          teff;
  logic [CB-1:0]        cap;
  logic                 pin_in;
  logic                 kind_in;
  logic                 in_acc;
  logic                 div_start;
  logic [NW-1:0]        div_num;
  logic [DW-1:0]        div_den;
  logic [NW-1:0]        div_quo;
  impwm_pkg::div_stat_t div_stat;
  impwm_pkg::status_t   status_c;
  logic [HW-1:0]        p95, p5, pk_lo, pk_hi;
  logic                 neg_res;

  // Input unpacking and effective tick rate.
  assign cap     = in_tdata[CB-1:0];
  assign pin_in  = in_tdata[32];
  assign kind_in = in_tuser[0];
  assign teff    = (tpm_r == 20'd0) ? 20'd1 : tpm_r;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign status_c  = impwm_pkg::status_of(freq_r);

  // Constant products used by the resistance and window steps.
  assign p95 = HW'(period_r) * HW'(impwm_pkg::K_PER);
  assign p5  = HW'(period_r) * HW'(impwm_pkg::K_DEN);
  assign pk_lo = HW'(period_r) * ((status_c == impwm_pkg::ST_START) ?
                 HW'(impwm_pkg::WIN_START_LO) : HW'(impwm_pkg::WIN_FAULT_LO));
  assign pk_hi = HW'(period_r) * ((status_c == impwm_pkg::ST_START) ?
                 HW'(impwm_pkg::WIN_START_HI) : HW'(impwm_pkg::WIN_FAULT_HI));
  assign neg_res = diff_neg_r ^ den_neg_r;

  // Divider operand selection by sequencer step.
  always_comb begin
    div_num = '0;
    div_den = '0;
    unique case (state_r)
      S_FREQ: begin
        div_num = NW'(teff) * NW'(impwm_pkg::FREQ_SCALE) + NW'(period_r);
        div_den = DW'({period_r, 1'b0});
      end
      S_PER: begin
        div_num = NW'({period_r, 1'b0}) + NW'(teff);
        div_den = DW'({teff, 1'b0});
      end
      S_DUTY: begin
        div_num = NW'(high_r) * NW'(impwm_pkg::DUTY_SCALE) + NW'(period_r);
        div_den = DW'({period_r, 1'b0});
      end
      S_RESDIV: begin
        div_num = num_mag_r;
        div_den = DW'(den_mag_r);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    launched_nxt   = launched_r;
    tpm_nxt        = tpm_r;
    last_rise_nxt  = last_rise_r;
    period_nxt     = period_r;
    high_nxt       = high_r;
    pin_nxt        = pin_r;
    freq_nxt       = freq_r;
    per_nxt        = per_r;
    duty_nxt       = duty_r;
    det_nxt        = det_r;
    h100_nxt       = h100_r;
    diff_neg_nxt   = diff_neg_r;
    den_neg_nxt    = den_neg_r;
    diff_mag_nxt   = diff_mag_r;
    den_mag_nxt    = den_mag_r;
    num_mag_nxt    = num_mag_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_det_nxt    = out_det_r;
    out_freq_nxt   = out_freq_r;
    out_per_nxt    = out_per_r;
    out_duty_nxt   = out_duty_r;
    div_start      = 1'b0;

    if (cfg_valid) begin
      tpm_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          pin_nxt      = pin_in;
          launched_nxt = 1'b0;
          state_nxt    = S_FREQ;
          if (!kind_in) begin
            if (pin_in) begin
              period_nxt    = cap - last_rise_r;
              last_rise_nxt = cap;
            end else begin
              high_nxt = cap - last_rise_r;
            end
          end
        end
      end
      S_FREQ: begin
        if (period_r == '0) begin
          freq_nxt  = 8'd0;
          state_nxt = S_PER;
        end else if (!launched_r) begin
          div_start    = 1'b1;
          launched_nxt = 1'b1;
        end else if (div_stat.done) begin
          freq_nxt     = (div_quo > NW'(impwm_pkg::FREQ_SAT)) ? 8'd255 : div_quo[7:0];
          launched_nxt = 1'b0;
          state_nxt    = S_PER;
        end
      end
      S_PER: begin
        if (!launched_r) begin
          div_start    = 1'b1;
          launched_nxt = 1'b1;
        end else if (div_stat.done) begin
          per_nxt      = (div_quo > NW'(impwm_pkg::PER_SAT)) ? 8'd255 : div_quo[7:0];
          launched_nxt = 1'b0;
          state_nxt    = S_DUTY;
        end
      end
      S_DUTY: begin
        if (period_r == '0) begin
          duty_nxt  = 15'd0;
          state_nxt = S_DET;
        end else if (!launched_r) begin
          div_start    = 1'b1;
          launched_nxt = 1'b1;
        end else if (div_stat.done) begin
          duty_nxt     = (div_quo > NW'(impwm_pkg::DUTY_SAT)) ?
                         15'(impwm_pkg::DUTY_SAT) : div_quo[14:0];
          launched_nxt = 1'b0;
          state_nxt    = S_DET;
        end
      end
      S_DET: begin
        // The status code picks what the detail value means.
        h100_nxt = HW'(high_r) * HW'(impwm_pkg::PCT);
        unique case (status_c)
          impwm_pkg::ST_SHORT: begin
            det_nxt   = {31'd0, ~pin_r};
            state_nxt = S_DONE;
          end
          impwm_pkg::ST_NORMAL, impwm_pkg::ST_UNDERV: begin
            state_nxt = S_RESA;
          end
          impwm_pkg::ST_START, impwm_pkg::ST_DEVERR, impwm_pkg::ST_EARTH: begin
            state_nxt = S_WIN;
          end
          default: begin
            det_nxt   = 32'hFFFF_FFFF;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_RESA: begin
        // Signs and magnitudes of 95P-100H and 100H-5P.
        diff_neg_nxt = (p95 < h100_r);
        diff_mag_nxt = (p95 < h100_r) ? (h100_r - p95) : (p95 - h100_r);
        den_neg_nxt  = (h100_r < p5);
        den_mag_nxt  = (h100_r < p5) ? (p5 - h100_r) : (h100_r - p5);
        state_nxt    = S_RESB;
      end
      S_RESB: begin
        if (den_mag_r == '0) begin
          det_nxt   = diff_neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
          state_nxt = S_DONE;
        end else begin
          num_mag_nxt  = NW'(diff_mag_r) * NW'(impwm_pkg::RES_SCALE);
          launched_nxt = 1'b0;
          state_nxt    = S_RESDIV;
        end
      end
      S_RESDIV: begin
        if (!launched_r) begin
          div_start    = 1'b1;
          launched_nxt = 1'b1;
        end else if (div_stat.done) begin
          // Apply the quotient sign and clamp to the 32-bit signed range.
          if (neg_res) begin
            det_nxt = (div_quo > NW'(32'h8000_0000)) ? 32'h8000_0000 : -div_quo[31:0];
          end else begin
            det_nxt = (div_quo > NW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_quo[31:0];
          end
          launched_nxt = 1'b0;
          state_nxt    = S_DONE;
        end
      end
      S_WIN: begin
        if (status_c == impwm_pkg::ST_START) begin
          if (h100_r < pk_lo) begin
            det_nxt = 32'd1;
          end else if (h100_r > pk_hi) begin
            det_nxt = 32'd0;
          end else begin
            det_nxt = 32'hFFFF_FFFF;
          end
        end else begin
          det_nxt = ((h100_r > pk_lo) && (h100_r < pk_hi)) ? 32'd1 : 32'hFFFF_FFFF;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hand the result to the output register once it is free.
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_status_nxt = status_c;
          out_det_nxt    = det_r;
          out_freq_nxt   = freq_r;
          out_per_nxt    = per_r;
          out_duty_nxt   = duty_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      launched_r   <= 1'b0;
      tpm_r        <= impwm_pkg::TPM_RESET;
      last_rise_r  <= '0;
      period_r     <= '0;
      high_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      launched_r   <= launched_nxt;
      tpm_r        <= tpm_nxt;
      last_rise_r  <= last_rise_nxt;
      period_r     <= period_nxt;
      high_r       <= high_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    pin_r        <= pin_nxt;
    freq_r       <= freq_nxt;
    per_r        <= per_nxt;
    duty_r       <= duty_nxt;
    det_r        <= det_nxt;
    h100_r       <= h100_nxt;
    diff_neg_r   <= diff_neg_nxt;
    den_neg_r    <= den_neg_nxt;
    diff_mag_r   <= diff_mag_nxt;
    den_mag_r    <= den_mag_nxt;
    num_mag_r    <= num_mag_nxt;
    out_status_r <= out_status_nxt;
    out_det_r    <= out_det_nxt;
    out_freq_r   <= out_freq_nxt;
    out_per_r    <= out_per_nxt;
    out_duty_r   <= out_duty_nxt;
  end

  // Shared divider for every quotient of an item.
  impwm_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  // Result beat outputs.
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {1'b0, out_duty_r, out_per_r, out_freq_r, out_det_r};

  // The divider is only started while idle.
  `IMPWM_ASSERT_IMPLIES(a_div_start_idle, clk, rst_n, div_start, !div_stat.busy)
  // An accepted beat moves the sequencer out of idle.
  `IMPWM_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_acc, state_r != S_IDLE)
  // A result appears only from the final sequencer step.
  `IMPWM_ASSERT_IMPLIES(a_result_from_done, clk, rst_n, $rose(out_tvalid_r),
                        $past(state_r == S_DONE))

endmodule

// ===== test/tb_insulation_monitor_pwm_decoder_top.sv =====
`timescale 1ns / 1ps

// Input beat codes.
localparam bit KIND_CAPTURE = 1'b0;
localparam bit KIND_POLL    = 1'b1;
localparam bit PIN_LOW      = 1'b0;
localparam bit PIN_HIGH     = 1'b1;

// Detail saturation bounds.
localparam int DETAIL_MAX = 32'sh7FFF_FFFF;
localparam int DETAIL_MIN = 32'sh8000_0000;

// One expected status report.
typedef struct {
  impwm_pkg::status_t status;
  logic signed [31:0] detail;
  logic [7:0]         freq;
  logic [7:0]         per_ms;
  logic [14:0]        duty;
} status_report_t;

// Tracks the edge timing state, predicts each report and checks result beats.
class pwm_status_scoreboard;
  bit [19:0]      tpm;
  bit [31:0]      last_rise;
  bit [31:0]      period_cnt;
  bit [31:0]      high_cnt;
  status_report_t reports_due[$];
  int             mismatches;

  function new();
    tpm        = 20'd1000;
    last_rise  = '0;
    period_cnt = '0;
    high_cnt   = '0;
    mismatches = 0;
  endfunction

  function void set_tpm(bit [19:0] value);
    tpm = value;
  endfunction

  function int pending();
    return reports_due.size();
  endfunction

  // Update the timing state for an accepted beat and queue the report it causes.
  function void note_item(bit kind, bit [31:0] stamp, bit level);
    longint unsigned eff, p, h, h100, fr, pm, dq;
    longint          sp, sh, num, den, q;
    status_report_t  r;
    if (kind == KIND_CAPTURE) begin
      if (level == PIN_HIGH) begin
        period_cnt = stamp - last_rise;
        last_rise  = stamp;
      end else begin
        high_cnt = stamp - last_rise;
      end
    end

    eff  = (tpm == 0) ? 1 : tpm;
    p    = period_cnt;
    h    = high_cnt;
    h100 = 100 * h;

    // Rounded frequency, period and duty, each saturated.
    fr = (p == 0) ? 0 : (2000 * eff + p) / (2 * p);
    if (fr > 255) fr = 255;
    pm = (2 * p + eff) / (2 * eff);
    if (pm > 255) pm = 255;
    dq = (p == 0) ? 0 : (51200 * h + p) / (2 * p);
    if (dq > 25600) dq = 25600;

    case (fr)
      0:       r.status = impwm_pkg::ST_SHORT;
      10:      r.status = impwm_pkg::ST_NORMAL;
      20:      r.status = impwm_pkg::ST_UNDERV;
      30:      r.status = impwm_pkg::ST_START;
      40:      r.status = impwm_pkg::ST_DEVERR;
      50:      r.status = impwm_pkg::ST_EARTH;
      default: r.status = impwm_pkg::ST_UNKNOWN;
    endcase

    // The detail value depends on the status.
    case (r.status)
      impwm_pkg::ST_SHORT: begin
        r.detail = (level == PIN_HIGH) ? 0 : 1;
      end
      impwm_pkg::ST_NORMAL, impwm_pkg::ST_UNDERV: begin
        sp  = p;
        sh  = h;
        num = 1200 * (95 * sp - 100 * sh);
        den = 100 * sh - 5 * sp;
        if (den == 0) begin
          r.detail = (num < 0) ? DETAIL_MIN : DETAIL_MAX;
        end else begin
          q = num / den;
          if (q > DETAIL_MAX) r.detail = DETAIL_MAX;
          else if (q < DETAIL_MIN) r.detail = DETAIL_MIN;
          else r.detail = q[31:0];
        end
      end
      impwm_pkg::ST_START: begin
        if (h100 < 15 * p) r.detail = 1;
        else if (h100 > 85 * p) r.detail = 0;
        else r.detail = -1;
      end
      impwm_pkg::ST_DEVERR, impwm_pkg::ST_EARTH: begin
        r.detail = (h100 > 45 * p && h100 < 55 * p) ? 1 : -1;
      end
      default: begin
        r.detail = -1;
      end
    endcase

    r.freq   = fr[7:0];
    r.per_ms = pm[7:0];
    r.duty   = dq[14:0];
    reports_due.push_back(r);
  endfunction

  // Compare one result beat with the oldest expected report.
  function void check_report(logic [63:0] data, logic [2:0] user);
    status_report_t want;
    if (reports_due.size() == 0) begin
      $error("result beat with no expected report: status_code %0d", user);
      mismatches++;
      return;
    end
    want = reports_due.pop_front();
    if (user !== want.status) begin
      $error("status_code: expected %0d, actual %0d", want.status, user);
      mismatches++;
    end
    if (data[31:0] !== want.detail) begin
      $error("detail_value: expected %0d, actual %0d", want.detail, $signed(data[31:0]));
      mismatches++;
    end
    if (data[39:32] !== want.freq) begin
      $error("frequency_hz: expected %0d, actual %0d", want.freq, data[39:32]);
      mismatches++;
    end
    if (data[47:40] !== want.per_ms) begin
      $error("period_ms: expected %0d, actual %0d", want.per_ms, data[47:40]);
      mismatches++;
    end
    if (data[62:48] !== want.duty) begin
      $error("duty_percent_q8: expected %0d, actual %0d", want.duty, data[62:48]);
      mismatches++;
    end
  endfunction
endclass

module tb_insulation_monitor_pwm_decoder_top;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // capture_time[31:0], pin_level[32], zero fill
  logic [0:0]  in_tuser;   // kind[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;  // detail_value[31:0], frequency_hz[39:32],
                           // period_ms[47:40], duty_percent_q8[62:48], zero fill
  logic [2:0]  out_tuser;  // status_code[2:0]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [19:0] cfg_data;

  pwm_status_scoreboard sb;
  int unsigned          burst_left = 0;
  int unsigned          items_sent = 0;
  bit [31:0]            stamp_now;
  bit [7:0]             rx_cycle = '0;
  int unsigned          rx_mode = 0;
  bit [19:0]            tpm_plan[7];

  insulation_monitor_pwm_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Result side: check accepted beats, then pick the next ready level from the stall mode.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_report(out_tdata, out_tuser);
    end
    rx_cycle <= rx_cycle + 8'd1;
    if (rx_cycle[5:0] == 6'd0) begin
      rx_mode = $urandom_range(0, 3);
    end
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= (rx_cycle[2:0] == 3'd0);
      default: out_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Send one input beat; bursts of random length are separated by random gaps.
  task automatic push_item(input bit kind, input bit [31:0] stamp, input bit level);
    int unsigned gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1, 2:    gap = $urandom_range(1, 8);
        default: gap = $urandom_range(1, 260);
      endcase
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, level, stamp};
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    sb.note_item(kind, stamp, level);
    burst_left--;
    items_sent++;
  endtask

  // Hold off the input until every expected report has come back.
  task automatic drain();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_tpm(input bit [19:0] value);
    drain();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_tpm(value);
  endtask

  // A run of clean PWM periods, mostly near a status frequency, with random duty and polls.
  task automatic send_pwm_burst();
    longint unsigned eff, hz, per, hi, jit;
    int unsigned     pct;
    eff = (sb.tpm == 0) ? 1 : sb.tpm;
    hz  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 300) : 10 * $urandom_range(1, 5);
    per = (1000 * eff + hz / 2) / hz;
    jit = per / 400;
    per = per + $urandom_range(0, 2 * jit) - jit;
    // Multiples of 100 let the duty windows be hit exactly.
    if (per >= 1000 && $urandom_range(0, 2) == 0) per = per - per % 100;
    case ($urandom_range(0, 9))
      0:       pct = 5;
      1:       pct = 15;
      2:       pct = 85;
      3:       pct = 45;
      4:       pct = 55;
      5:       pct = $urandom_range(101, 200);
      default: pct = $urandom_range(0, 100);
    endcase
    hi = per * pct / 100;
    if (hi != 0 && $urandom_range(0, 3) == 0) hi = hi + $urandom_range(0, 2) - 1;
    repeat ($urandom_range(1, 6)) begin
      push_item(KIND_CAPTURE, stamp_now, PIN_HIGH);
      if ($urandom_range(0, 4) == 0) push_item(KIND_POLL, $urandom, 1'($urandom_range(0, 1)));
      push_item(KIND_CAPTURE, stamp_now + hi[31:0], PIN_LOW);
      if ($urandom_range(0, 4) == 0) push_item(KIND_POLL, $urandom, 1'($urandom_range(0, 1)));
      stamp_now = stamp_now + per[31:0];
    end
  endtask

  // Broken sequences: repeated rises, stray falls and time running backwards.
  task automatic send_broken();
    case ($urandom_range(0, 2))
      0: begin
        push_item(KIND_CAPTURE, stamp_now, PIN_HIGH);
        stamp_now = stamp_now + $urandom_range(0, 2000);
        push_item(KIND_CAPTURE, stamp_now, PIN_HIGH);
      end
      1: begin
        push_item(KIND_CAPTURE, stamp_now + $urandom, PIN_LOW);
      end
      default: begin
        stamp_now = stamp_now - $urandom_range(1, 5000);
        push_item(KIND_CAPTURE, stamp_now, PIN_HIGH);
      end
    endcase
  endtask

  task automatic run_phase(input int unsigned target);
    int unsigned start;
    int unsigned pick;
    start = items_sent;
    while (items_sent - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_pwm_burst();
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) begin
          push_item(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
        end
      end else if (pick < 97) begin
        send_broken();
      end else begin
        drain();
      end
    end
  endtask

  // Stimulus.
  initial begin
    sb        = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    stamp_now = $urandom;
    tpm_plan  = '{20'd1, 20'd0, 20'hFFFFF, 20'd1000000, 20'd1000, 20'd7, 20'd0};
    tpm_plan[6] = 20'($urandom_range(2, 20'hFFFFF));
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset tick rate: polls with no period, each status,
    // a zero resistance denominator, high time beyond the period and counter wrap.
    push_item(KIND_POLL, $urandom, PIN_LOW);
    push_item(KIND_POLL, $urandom, PIN_HIGH);
    push_item(KIND_CAPTURE, 32'd0, PIN_HIGH);
    push_item(KIND_CAPTURE, 32'd5000, PIN_LOW);
    push_item(KIND_CAPTURE, 32'd100000, PIN_HIGH);
    push_item(KIND_CAPTURE, 32'd130000, PIN_LOW);
    push_item(KIND_CAPTURE, 32'd200000, PIN_HIGH);
    push_item(KIND_CAPTURE, 32'd295000, PIN_LOW);
    push_item(KIND_CAPTURE, 32'd250000, PIN_HIGH);
    push_item(KIND_CAPTURE, 32'd250001, PIN_LOW);
    push_item(KIND_CAPTURE, 32'd283333, PIN_HIGH);
    push_item(KIND_CAPTURE, 32'd313333, PIN_LOW);
    push_item(KIND_CAPTURE, 32'd300000, PIN_LOW);
    push_item(KIND_CAPTURE, 32'd308333, PIN_HIGH);
    push_item(KIND_CAPTURE, 32'd320833, PIN_LOW);
    push_item(KIND_CAPTURE, 32'd328333, PIN_HIGH);
    push_item(KIND_CAPTURE, 32'd338333, PIN_LOW);
    push_item(KIND_CAPTURE, 32'd340678, PIN_HIGH);
    push_item(KIND_CAPTURE, 32'hFFFF_FFF0, PIN_HIGH);
    push_item(KIND_CAPTURE, 32'h0000_0010, PIN_HIGH);
    push_item(KIND_CAPTURE, 32'h0000_000F, PIN_HIGH);
    push_item(KIND_CAPTURE, 32'hFFFF_FFFF, PIN_LOW);
    push_item(KIND_POLL, 32'hFFFF_FFFF, PIN_HIGH);

    // Random part, one phase per tick rate.
    foreach (tpm_plan[i]) begin
      write_tpm(tpm_plan[i]);
      run_phase(275);
    end

    drain();
    repeat (300) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb_insulation_monitor_pwm_decoder_top: PASS");
    end else begin
      $display("tb_insulation_monitor_pwm_decoder_top: FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #40_000_000;
    $display("tb_insulation_monitor_pwm_decoder_top: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/impwm_pkg.sv
sv/impwm_div.sv
sv/insulation_monitor_pwm_decoder_top.sv
test/tb_insulation_monitor_pwm_decoder_top.sv
